// ----- hdl/tbva_pkg.sv -----
// Shared types and constants for the time-bucketed volume aggregator.
package tbva_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam logic [1:0] SIDE_AGG  = 2'd0;
  localparam logic [1:0] SIDE_BUY  = 2'd1;
  localparam logic [1:0] SIDE_SELL = 2'd2;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_DUMP  = 1'b1;

  localparam logic [2:0] REG_BUCKET_SIZE = 3'd0;
  localparam logic [2:0] REG_GROUP_SIDE  = 3'd1;
  localparam logic [2:0] REG_GROUP_SYM   = 3'd2;
  localparam logic [2:0] REG_BOOKS_ONLY  = 3'd3;
  localparam logic [2:0] REG_FILTER_CNT  = 3'd4;
  localparam logic [2:0] REG_FILTER_A    = 3'd5;
  localparam logic [2:0] REG_FILTER_B    = 3'd6;
  localparam logic [2:0] REG_FILTER_CD   = 3'd7;

  localparam logic [62:0] BUCKET_SIZE_RESET = 63'd1000000000;

  typedef struct packed {
    logic [63:0] bucket;
    logic [31:0] symbol;
    logic [1:0]  side;
    logic [63:0] sum;
  } tbva_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIX,
    ST_BKT,
    ST_SRCH,
    ST_CMP,
    ST_INS,
    ST_SHIFT,
    ST_MOVE,
    ST_DUMP_RD,
    ST_DUMP_OUT,
    ST_DUMP_EMPTY
  } tbva_state_t;

endpackage

// ----- hdl/tbva_div.sv -----
// Bit-serial unsigned remainder unit, one quotient bit per cycle.
module tbva_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] rem
);

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        run_r, run_nxt;
  logic        done_r, done_nxt;
  logic [63:0] shifted;

  // The partial remainder stays below the divisor, so its top bit is free.
  assign shifted = {rem_r[62:0], a_r[63]};

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      a_nxt   = dividend;
      b_nxt   = divisor;
      rem_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      a_nxt   = {a_r[62:0], 1'b0};
      rem_nxt = (shifted >= b_r) ? (shifted - b_r) : shifted;
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ----- hdl/time_bucket_volume_aggregator.sv -----
// Top level: configuration, sequencer and ordered entry table of the aggregator.
//
// An event item runs a serial remainder for the bucket floor, then a search
// step (ST_SRCH, ST_CMP) per table entry walked past during the ordered
// search, then a step (ST_SHIFT, ST_MOVE) per entry moved to open an
// insertion slot. A dump item reads each row (ST_DUMP_RD, ST_DUMP_OUT)
// and emits one row per strobe on out_valid; the receiver must take each row
// in the cycle it appears. busy is high from an accepted dump or kept trade
// event until its work is finished; the table is not cleared by a dump.
module time_bucket_volume_aggregator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic        in_is_trade,
  input  logic [63:0] in_timestamp,
  input  logic [31:0] in_symbol,
  input  logic        in_trade_side,
  input  logic [63:0] in_quantity,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [63:0] out_row_bucket,
  output logic [31:0] out_row_symbol,
  output logic [1:0]  out_row_side,
  output logic [63:0] out_row_sum,
  output logic        out_row_valid,
  output logic        out_row_last,
  output logic        out_table_overflowed
);

  localparam int AW = tbva_pkg::ADDR_W;
  localparam int CW = tbva_pkg::CNT_W;

  tbva_pkg::tbva_state_t state_r, state_nxt;

  logic [62:0] bucket_size_r;
  logic        group_side_r, group_sym_r, books_only_r;
  logic [2:0]  filter_cnt_r;
  logic [31:0] filter_a_r, filter_b_r;
  logic [63:0] filter_cd_r;

  logic [CW-1:0] used_r, used_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          ovf_r, ovf_nxt;

  logic [63:0] ts_r, ts_nxt;
  logic [31:0] sym_r, sym_nxt;
  logic [1:0]  side_r, side_nxt;
  logic [63:0] qty_r, qty_nxt;
  logic [63:0] rmd_r, rmd_nxt;
  logic [63:0] bkt_r, bkt_nxt;

  tbva_pkg::tbva_entry_t mem [tbva_pkg::TABLE_ENTRIES];
  tbva_pkg::tbva_entry_t rd_q_r;
  tbva_pkg::tbva_entry_t wdata;
  logic [AW-1:0] raddr, waddr;
  logic          we;

  logic [63:0] divisor, dividend, div_rem;
  logic        div_start, div_done;

  logic        accept, pass;
  logic [2:0]  n_eff;
  logic        key_less, key_eq;
  logic [CW-1:0] k_dec;

  assign accept = start && !busy;
  assign n_eff  = (filter_cnt_r > 3'd4) ? 3'd4 : filter_cnt_r;
  assign pass   = (n_eff == 3'd0)
               || ((n_eff >= 3'd1) && (in_symbol == filter_a_r))
               || ((n_eff >= 3'd2) && (in_symbol == filter_b_r))
               || ((n_eff >= 3'd3) && (in_symbol == filter_cd_r[31:0]))
               || ((n_eff >= 3'd4) && (in_symbol == filter_cd_r[63:32]));

  // The divider loads its operands at the accepting edge, so it takes the live timestamp.
  assign divisor  = (bucket_size_r == '0) ? 64'd1 : {1'b0, bucket_size_r};
  assign dividend = in_timestamp[63] ? (64'd0 - in_timestamp) : in_timestamp;
  assign k_dec    = k_r - CW'(1);

  // Keys order by signed bucket, then symbol, then side.
  always_comb begin
    key_eq   = (rd_q_r.bucket == bkt_r) && (rd_q_r.symbol == sym_r)
            && (rd_q_r.side == side_r);
    key_less = ($signed(rd_q_r.bucket) < $signed(bkt_r))
            || ((rd_q_r.bucket == bkt_r) && (rd_q_r.symbol < sym_r))
            || ((rd_q_r.bucket == bkt_r) && (rd_q_r.symbol == sym_r)
                && (rd_q_r.side < side_r));
  end

  tbva_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .rem      (div_rem)
  );

  // Next state and datapath registers.
  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    ovf_nxt   = ovf_r;
    ts_nxt    = ts_r;
    sym_nxt   = sym_r;
    side_nxt  = side_r;
    qty_nxt   = qty_r;
    rmd_nxt   = rmd_r;
    bkt_nxt   = bkt_r;
    case (state_r)
      tbva_pkg::ST_IDLE: begin
        pos_nxt = '0;
        if (accept) begin
          if (in_cmd == tbva_pkg::CMD_DUMP) begin
            state_nxt = (used_r == '0) ? tbva_pkg::ST_DUMP_EMPTY : tbva_pkg::ST_DUMP_RD;
          end else if (in_is_trade && !books_only_r && pass) begin
            ts_nxt    = in_timestamp;
            sym_nxt   = group_sym_r ? in_symbol : 32'd0;
            side_nxt  = !group_side_r ? tbva_pkg::SIDE_AGG :
                        (in_trade_side ? tbva_pkg::SIDE_SELL : tbva_pkg::SIDE_BUY);
            qty_nxt   = in_quantity;
            state_nxt = tbva_pkg::ST_DIV;
          end
        end
      end
      tbva_pkg::ST_DIV: begin
        if (div_done) begin
          if (!ts_r[63]) rmd_nxt = div_rem;
          else rmd_nxt = (div_rem == '0) ? 64'd0 : (divisor - div_rem);
          state_nxt = tbva_pkg::ST_FIX;
        end
      end
      tbva_pkg::ST_FIX: begin
        bkt_nxt   = ts_r - rmd_r;
        state_nxt = tbva_pkg::ST_BKT;
      end
      tbva_pkg::ST_BKT: state_nxt = tbva_pkg::ST_SRCH;
      tbva_pkg::ST_SRCH: begin
        state_nxt = (pos_r == used_r) ? tbva_pkg::ST_INS : tbva_pkg::ST_CMP;
      end
      tbva_pkg::ST_CMP: begin
        if (key_eq) begin
          state_nxt = tbva_pkg::ST_IDLE;
        end else if (key_less) begin
          pos_nxt   = pos_r + CW'(1);
          state_nxt = tbva_pkg::ST_SRCH;
        end else begin
          state_nxt = tbva_pkg::ST_INS;
        end
      end
      tbva_pkg::ST_INS: begin
        if (used_r >= CW'(tbva_pkg::TABLE_ENTRIES)) begin
          ovf_nxt   = 1'b1;
          state_nxt = tbva_pkg::ST_IDLE;
        end else begin
          k_nxt     = used_r;
          state_nxt = tbva_pkg::ST_SHIFT;
        end
      end
      tbva_pkg::ST_SHIFT: begin
        if (k_r == pos_r) begin
          used_nxt  = used_r + CW'(1);
          state_nxt = tbva_pkg::ST_IDLE;
        end else begin
          state_nxt = tbva_pkg::ST_MOVE;
        end
      end
      tbva_pkg::ST_MOVE: begin
        k_nxt     = k_dec;
        state_nxt = tbva_pkg::ST_SHIFT;
      end
      tbva_pkg::ST_DUMP_RD: state_nxt = tbva_pkg::ST_DUMP_OUT;
      tbva_pkg::ST_DUMP_OUT: begin
        pos_nxt   = pos_r + CW'(1);
        state_nxt = (pos_r + CW'(1) == used_r) ? tbva_pkg::ST_IDLE : tbva_pkg::ST_DUMP_RD;
      end
      tbva_pkg::ST_DUMP_EMPTY: state_nxt = tbva_pkg::ST_IDLE;
      default: state_nxt = tbva_pkg::ST_IDLE;
    endcase
  end

  // Memory control, divider launch and result ports.
  always_comb begin
    raddr     = pos_r[AW-1:0];
    waddr     = pos_r[AW-1:0];
    we        = 1'b0;
    wdata     = rd_q_r;
    div_start = 1'b0;
    out_valid      = 1'b0;
    out_row_bucket = rd_q_r.bucket;
    out_row_symbol = rd_q_r.symbol;
    out_row_side   = rd_q_r.side;
    out_row_sum    = rd_q_r.sum;
    out_row_valid  = 1'b1;
    out_row_last   = (pos_r + CW'(1) == used_r);
    case (state_r)
      tbva_pkg::ST_IDLE: div_start = accept && (in_cmd == tbva_pkg::CMD_EVENT)
                                     && in_is_trade && !books_only_r && pass;
      tbva_pkg::ST_BKT: div_start = 1'b0;
      tbva_pkg::ST_CMP: begin
        if (key_eq) begin
          we        = 1'b1;
          wdata.sum = rd_q_r.sum + qty_r;
        end
      end
      tbva_pkg::ST_SHIFT: begin
        raddr = k_dec[AW-1:0];
        if (k_r == pos_r) begin
          we           = 1'b1;
          wdata.bucket = bkt_r;
          wdata.symbol = sym_r;
          wdata.side   = side_r;
          wdata.sum    = qty_r;
        end
      end
      tbva_pkg::ST_MOVE: begin
        we    = 1'b1;
        waddr = k_r[AW-1:0];
      end
      tbva_pkg::ST_DUMP_OUT: out_valid = 1'b1;
      tbva_pkg::ST_DUMP_EMPTY: begin
        out_valid      = 1'b1;
        out_row_bucket = '0;
        out_row_symbol = '0;
        out_row_side   = tbva_pkg::SIDE_AGG;
        out_row_sum    = '0;
        out_row_valid  = 1'b0;
        out_row_last   = 1'b1;
      end
      default: ;
    endcase
  end

  assign out_table_overflowed = ovf_r;
  assign busy = (state_r != tbva_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tbva_pkg::ST_IDLE;
      used_r        <= '0;
      pos_r         <= '0;
      k_r           <= '0;
      ovf_r         <= 1'b0;
      bucket_size_r <= tbva_pkg::BUCKET_SIZE_RESET;
      group_side_r  <= 1'b0;
      group_sym_r   <= 1'b0;
      books_only_r  <= 1'b0;
      filter_cnt_r  <= '0;
      filter_a_r    <= '0;
      filter_b_r    <= '0;
      filter_cd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
      ovf_r   <= ovf_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tbva_pkg::REG_BUCKET_SIZE: bucket_size_r <= cfg_data[62:0];
          tbva_pkg::REG_GROUP_SIDE:  group_side_r  <= cfg_data[0];
          tbva_pkg::REG_GROUP_SYM:   group_sym_r   <= cfg_data[0];
          tbva_pkg::REG_BOOKS_ONLY:  books_only_r  <= cfg_data[0];
          tbva_pkg::REG_FILTER_CNT:  filter_cnt_r  <= cfg_data[2:0];
          tbva_pkg::REG_FILTER_A:    filter_a_r    <= cfg_data[31:0];
          tbva_pkg::REG_FILTER_B:    filter_b_r    <= cfg_data[31:0];
          tbva_pkg::REG_FILTER_CD:   filter_cd_r   <= cfg_data;
          default: ;
        endcase
      end
    end
    ts_r   <= ts_nxt;
    sym_r  <= sym_nxt;
    side_r <= side_nxt;
    qty_r  <= qty_nxt;
    rmd_r  <= rmd_nxt;
    bkt_r  <= bkt_nxt;
  end

endmodule
